// ===== rtl/core/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

  // field and register widths
  localparam int ECHO_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = 16;
  localparam int SUM_W   = 16;
  localparam int CFG_IDX_W = 3;

  // fixed scale factors
  localparam int ECHO_PER_CM = 58;
  localparam int GAIN_SCALE  = 10;
  localparam int DUTY_TOP    = 199;
  localparam int CTRL_TOP    = 255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_DUTY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_DEPTH  = 3'd6;

  // register reset values
  localparam logic [BYTE_W-1:0] SETPOINT_RST   = 8'd25;
  localparam logic [BYTE_W-1:0] TANK_DEPTH_RST = 8'd30;

endpackage

`default_nettype wire

// ===== rtl/core/level_pid_step.sv =====
// Path: in closed loop an item passes the echo divider, the shift-and-add multipliers,
// the divide-by-ten dividers and the duty scale divider; in open loop only the echo
// divider. The bit-serial dividers stand three in series.
// Flow: one item at a time; a new item is taken once the previous result sits in
// the output register.
// Reset (rst, synchronous): configuration registers return to defaults, error and control state clear.
`default_nettype none

module level_pid_step
  import lps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // s_tdata: echo_time[15:0]
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [ECHO_W-1:0]    s_tdata,
  // m_tdata: duty[7:0], distance_cm[15:8], error_now[23:16], control_value[31:24]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [4*BYTE_W-1:0]       m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIST  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV10 = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [BYTE_W-1:0] DUTY_MAX = BYTE_W'(DUTY_TOP);
  localparam logic [BYTE_W-1:0] CTRL_MAX = BYTE_W'(CTRL_TOP);

  // configuration
  logic [BYTE_W-1:0] setpoint;
  logic [BYTE_W-1:0] gain_p;
  logic [BYTE_W-1:0] gain_i;
  logic [BYTE_W-1:0] gain_d;
  logic              closed_loop;
  logic [BYTE_W-1:0] manual_duty;
  logic [BYTE_W-1:0] tank_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= SETPOINT_RST;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      closed_loop <= 1'b1;
      manual_duty <= '0;
      tank_depth  <= TANK_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:    setpoint    <= cfg_data;
        REG_GAIN_P:      gain_p      <= cfg_data;
        REG_GAIN_I:      gain_i      <= cfg_data;
        REG_GAIN_D:      gain_d      <= cfg_data;
        REG_CLOSED_LOOP: closed_loop <= cfg_data[0];
        REG_MANUAL_DUTY: manual_duty <= cfg_data;
        REG_TANK_DEPTH:  tank_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0] state;

  // regulator state
  logic signed [BYTE_W-1:0] prev_err;
  logic        [BYTE_W-1:0] accum;

  // per-item working registers
  logic        [BYTE_W-1:0] dist_cm;
  logic signed [BYTE_W-1:0] err;
  logic        [BYTE_W-1:0] duty;
  logic        [BYTE_W-1:0] mag_p;
  logic        [BYTE_W-1:0] mag_i;
  logic        [BYTE_W-1:0] mag_d;
  logic                     neg_p;
  logic                     neg_i;
  logic                     neg_d;

  // serial units
  logic              echo_start;
  logic              echo_busy;
  logic [ECHO_W-1:0] echo_q;
  logic              mul_start;
  logic              mul_busy_p;
  logic              mul_busy_i;
  logic              mul_busy_d;
  logic [PROD_W-1:0] prod_p;
  logic [PROD_W-1:0] prod_i;
  logic [PROD_W-1:0] prod_d;
  logic              ten_start;
  logic              ten_busy_p;
  logic              ten_busy_i;
  logic              ten_busy_d;
  logic [PROD_W-1:0] q_p;
  logic [PROD_W-1:0] q_i;
  logic [PROD_W-1:0] q_d;
  logic              scale_start;
  logic              scale_busy;
  logic [PROD_W-1:0] scale_q;
  logic [PROD_W-1:0] scale_num;

  logic                     accept;
  logic                     out_free;
  logic        [BYTE_W-1:0] dist_sat;
  logic signed [BYTE_W+1:0] err_wide;
  logic signed [BYTE_W-1:0] err_sat;
  logic signed [BYTE_W:0]   diff9;
  logic signed [SUM_W-1:0]  term_p;
  logic signed [SUM_W-1:0]  term_i;
  logic signed [SUM_W-1:0]  term_d;
  logic signed [SUM_W-1:0]  sum;
  logic        [BYTE_W-1:0] ctrl_next;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign echo_start  = accept;
  assign mul_start   = (state == S_PREP);
  assign ten_start   = (state == S_MUL) && !mul_busy_p && !mul_busy_i && !mul_busy_d;
  assign scale_start = (state == S_SUM);
  assign scale_num   = PROD_W'(accum) * PROD_W'(DUTY_TOP);

  lps_cdiv #(.WIDTH(ECHO_W), .DIVISOR(ECHO_PER_CM)) u_echo_div (
    .clk(clk), .rst(rst), .start(echo_start), .dividend(s_tdata),
    .busy(echo_busy), .quotient(echo_q)
  );

  lps_smul #(.AW(BYTE_W), .BW(BYTE_W)) u_mul_p (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_p), .b(gain_p),
    .busy(mul_busy_p), .prod(prod_p)
  );

  lps_smul #(.AW(BYTE_W), .BW(BYTE_W)) u_mul_i (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_i), .b(gain_i),
    .busy(mul_busy_i), .prod(prod_i)
  );

  lps_smul #(.AW(BYTE_W), .BW(BYTE_W)) u_mul_d (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_d), .b(gain_d),
    .busy(mul_busy_d), .prod(prod_d)
  );

  lps_cdiv #(.WIDTH(PROD_W), .DIVISOR(GAIN_SCALE)) u_ten_p (
    .clk(clk), .rst(rst), .start(ten_start), .dividend(prod_p),
    .busy(ten_busy_p), .quotient(q_p)
  );

  lps_cdiv #(.WIDTH(PROD_W), .DIVISOR(GAIN_SCALE)) u_ten_i (
    .clk(clk), .rst(rst), .start(ten_start), .dividend(prod_i),
    .busy(ten_busy_i), .quotient(q_i)
  );

  lps_cdiv #(.WIDTH(PROD_W), .DIVISOR(GAIN_SCALE)) u_ten_d (
    .clk(clk), .rst(rst), .start(ten_start), .dividend(prod_d),
    .busy(ten_busy_d), .quotient(q_d)
  );

  lps_cdiv #(.WIDTH(PROD_W), .DIVISOR(CTRL_TOP)) u_scale_div (
    .clk(clk), .rst(rst), .start(scale_start), .dividend(scale_num),
    .busy(scale_busy), .quotient(scale_q)
  );

  // distance and error
  always_comb begin
    dist_sat = (echo_q[ECHO_W-1:BYTE_W] != '0) ? CTRL_MAX : echo_q[BYTE_W-1:0];
    err_wide = $signed({2'b00, setpoint}) - $signed({2'b00, tank_depth})
             + $signed({2'b00, dist_sat});
    if (err_wide < -10'sd128) begin
      err_sat = -8'sd128;
    end else if (err_wide > 10'sd127) begin
      err_sat = 8'sd127;
    end else begin
      err_sat = err_wide[BYTE_W-1:0];
    end
  end

  assign diff9 = $signed({err[BYTE_W-1], err}) - $signed({prev_err[BYTE_W-1], prev_err});

  // signs go back on after the truncating divide
  always_comb begin
    term_p = neg_p ? -$signed(q_p) : $signed(q_p);
    term_i = neg_i ? -$signed(q_i) : $signed(q_i);
    term_d = neg_d ? -$signed(q_d) : $signed(q_d);
    sum    = $signed({{(SUM_W-BYTE_W){1'b0}}, accum}) + term_p + term_i + term_d;
    if (sum < 0) begin
      ctrl_next = '0;
    end else if (sum > $signed(SUM_W'(CTRL_TOP))) begin
      ctrl_next = CTRL_MAX;
    end else begin
      ctrl_next = sum[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prev_err <= '0;
      accum    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIST;
          end
        end
        S_DIST: begin
          if (!echo_busy) begin
            dist_cm <= dist_sat;
            if (closed_loop) begin
              err   <= err_sat;
              state <= S_PREP;
            end else begin
              // hold the regulator, report its state
              err   <= prev_err;
              duty  <= (manual_duty > DUTY_MAX) ? DUTY_MAX : manual_duty;
              state <= S_OUT;
            end
          end
        end
        S_PREP: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (ten_start) begin
            state <= S_DIV10;
          end
        end
        S_DIV10: begin
          if (!ten_busy_p && !ten_busy_i && !ten_busy_d) begin
            accum    <= ctrl_next;
            prev_err <= err;
            state    <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (!scale_busy) begin
            duty  <= scale_q[BYTE_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {accum, err, dist_cm, duty};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand magnitudes for the multipliers, stable while they start
  always_comb begin
    neg_p = err[BYTE_W-1];
    mag_p = err[BYTE_W-1] ? BYTE_W'(-err) : err;
    neg_i = prev_err[BYTE_W-1];
    mag_i = prev_err[BYTE_W-1] ? BYTE_W'(-prev_err) : prev_err;
    neg_d = diff9[BYTE_W];
    mag_d = diff9[BYTE_W] ? BYTE_W'(-diff9) : diff9[BYTE_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lps_cdiv.sv =====
`default_nettype none

// Restoring divider by a fixed constant, one quotient bit per cycle.
module lps_cdiv
  import lps_pkg::*;
#(
  parameter int WIDTH   = ECHO_W,
  parameter int DIVISOR = ECHO_PER_CM
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  output logic                  busy,
  output logic      [WIDTH-1:0] quotient
);

  localparam int RW = $clog2(DIVISOR);
  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [RW:0] DIV_C = (RW + 1)'(DIVISOR);

  logic [WIDTH-1:0] num;
  logic [RW-1:0]    rem;
  logic [CW-1:0]    count;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             qbit;

  assign trial = {rem, num[WIDTH-1]};
  assign qbit  = (trial >= DIV_C);
  assign diff  = trial - DIV_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(WIDTH);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (count != '0) begin
      // shift the quotient bit in where the dividend bit left
      num <= {num[WIDTH-2:0], qbit};
      rem <= qbit ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  assign busy     = (count != '0);
  assign quotient = num;

endmodule

`default_nettype wire

// ===== rtl/core/lps_smul.sv =====
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle.
module lps_smul
  import lps_pkg::*;
#(
  parameter int AW = BYTE_W,
  parameter int BW = BYTE_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic                    busy,
  output logic      [AW+BW-1:0]   prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc;
  logic [PW-1:0] a_sh;
  logic [BW-1:0] b_sh;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(BW);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= PW'(a);
      b_sh <= b;
    end else if (count != '0) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[PW-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[BW-1:1]};
    end
  end

  assign busy = (count != '0);
  assign prod = acc;

endmodule

`default_nettype wire

// ===== tb/sv/tb_level_pid_step.sv =====
module tb_level_pid_step;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int QUIET_TAIL = 60;

  typedef enum logic {DO_ECHO, DO_WRITE} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [ECHO_W-1:0]    echo;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    value;
  } step_t;

  // packed so that duty lands in the low byte, as on m_tdata
  typedef struct packed {
    logic [BYTE_W-1:0] control;
    logic [BYTE_W-1:0] err;
    logic [BYTE_W-1:0] dist_cm;
    logic [BYTE_W-1:0] duty;
  } level_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ECHO_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [4*BYTE_W-1:0]  m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  step_t         echo_plan[$];
  level_result_t due_results[$];
  int            total_items = 0;
  int            items_taken = 0;
  int            fail_count = 0;
  int            send_gap = 0;
  int            recv_stall = 0;

  // regulator settings and state as the block should hold them
  logic [BYTE_W-1:0]        set_level = SETPOINT_RST;
  logic [BYTE_W-1:0]        kp = '0;
  logic [BYTE_W-1:0]        ki = '0;
  logic [BYTE_W-1:0]        kd = '0;
  logic                     loop_on = 1'b1;
  logic [BYTE_W-1:0]        manual_level = '0;
  logic [BYTE_W-1:0]        depth_cm = TANK_DEPTH_RST;
  logic signed [BYTE_W-1:0] last_err = '0;
  logic [BYTE_W-1:0]        ctrl_held = '0;

  level_pid_step uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [BYTE_W-1:0] val);
    case (idx)
      REG_SETPOINT:    set_level = val;
      REG_GAIN_P:      kp = val;
      REG_GAIN_I:      ki = val;
      REG_GAIN_D:      kd = val;
      REG_CLOSED_LOOP: loop_on = val[0];
      REG_MANUAL_DUTY: manual_level = val;
      REG_TANK_DEPTH:  depth_cm = val;
      default: ;
    endcase
  endfunction

  // one regulator step; advances the held error and control value in closed loop
  function automatic level_result_t pid_update(input logic [ECHO_W-1:0] echo);
    level_result_t r;
    int dist_v, err, p_term, i_term, d_term, ctrl, duty;
    dist_v = int'(echo) / ECHO_PER_CM;
    if (dist_v > 255) dist_v = 255;
    if (loop_on) begin
      err = int'(set_level) - (int'(depth_cm) - dist_v);
      if (err > 127) err = 127;
      else if (err < -128) err = -128;
      p_term = (err * int'(kp)) / GAIN_SCALE;
      i_term = (int'(last_err) * int'(ki)) / GAIN_SCALE;
      d_term = ((err - int'(last_err)) * int'(kd)) / GAIN_SCALE;
      ctrl = int'(ctrl_held) + p_term + i_term + d_term;
      if (ctrl < 0) ctrl = 0;
      else if (ctrl > CTRL_TOP) ctrl = CTRL_TOP;
      last_err = err[BYTE_W-1:0];
      ctrl_held = ctrl[BYTE_W-1:0];
      duty = (ctrl * DUTY_TOP) / CTRL_TOP;
    end else begin
      err = int'(last_err);
      ctrl = int'(ctrl_held);
      duty = (int'(manual_level) > DUTY_TOP) ? DUTY_TOP : int'(manual_level);
    end
    r.duty = duty[BYTE_W-1:0];
    r.dist_cm = dist_v[BYTE_W-1:0];
    r.err = err[BYTE_W-1:0];
    r.control = ctrl[BYTE_W-1:0];
    return r;
  endfunction

  task automatic add_echo(input logic [ECHO_W-1:0] echo);
    step_t s;
    s.kind = DO_ECHO;
    s.echo = echo;
    s.index = '0;
    s.value = '0;
    echo_plan.push_back(s);
    total_items++;
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    step_t s;
    s.kind = DO_WRITE;
    s.echo = '0;
    s.index = idx;
    s.value = val;
    echo_plan.push_back(s);
  endtask

  function automatic logic [BYTE_W-1:0] pick_gain();
    int roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return BYTE_W'($urandom_range(0, 40));
  endfunction

  // sender: a write waits until the block has drained; items go out with random gaps
  always @(posedge clk) begin : feed
    logic                 v_n, we_n;
    logic [ECHO_W-1:0]    d_n;
    logic [CFG_IDX_W-1:0] idx_n;
    logic [BYTE_W-1:0]    wd_n;
    step_t                head;
    v_n = s_tvalid;
    d_n = s_tdata;
    we_n = 1'b0;
    idx_n = cfg_index;
    wd_n = cfg_data;
    if (rst) begin
      v_n = 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) v_n = 1'b0;
      if (!v_n) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (echo_plan.size() > 0) begin
          head = echo_plan[0];
          if (head.kind == DO_WRITE) begin
            if (!s_tvalid && due_results.size() == 0) begin
              void'(echo_plan.pop_front());
              we_n = 1'b1;
              idx_n = head.index;
              wd_n = head.value;
              apply_write(head.index, head.value);
            end
          end else if (items_taken < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
          end else begin
            void'(echo_plan.pop_front());
            v_n = 1'b1;
            d_n = head.echo;
          end
        end
      end
    end
    s_tvalid <= v_n;
    s_tdata <= d_n;
    cfg_we <= we_n;
    cfg_index <= idx_n;
    cfg_data <= wd_n;
  end

  // predict at each accepted input transaction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      due_results.push_back(pid_update(s_tdata));
      items_taken++;
    end
  end

  // receiver: check each result transaction and stall at random
  always @(posedge clk) begin : drain
    level_result_t got, want;
    logic          rdy_n;
    rdy_n = 1'b1;
    if (rst) begin
      rdy_n = 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = level_result_t'(m_tdata);
        if (due_results.size() == 0) begin
          report($sformatf("result %h with nothing pending", m_tdata));
        end else begin
          want = due_results.pop_front();
          if (got.duty !== want.duty)
            report($sformatf("duty %0d, want %0d", got.duty, want.duty));
          if (got.dist_cm !== want.dist_cm)
            report($sformatf("distance_cm %0d, want %0d", got.dist_cm, want.dist_cm));
          if (got.err !== want.err)
            report($sformatf("error_now %0d, want %0d",
                             $signed(got.err), $signed(want.err)));
          if (got.control !== want.control)
            report($sformatf("control_value %0d, want %0d", got.control, want.control));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rdy_n = 1'b0;
      end else if (items_taken < total_items - QUIET_TAIL && $urandom_range(0, 6) == 0) begin
        recv_stall = $urandom_range(1, 11) - 1;
        rdy_n = 1'b0;
      end
    end
    m_tready <= rdy_n;
  end

  initial begin
    int ph, n, center, dist_pick;
    logic [BYTE_W-1:0] sp, dp;
    logic [ECHO_W-1:0] e;

    // distance conversion at defaults: zero, cm boundaries, saturation, bit patterns
    add_echo(16'd0);
    add_echo(16'd57);
    add_echo(16'd58);
    add_echo(16'hFFFF);
    add_echo(16'd14790);
    add_echo(16'd14789);
    add_echo(16'h5555);
    add_echo(16'hAAAA);
    // full gains, error pinned high then low
    add_write(REG_GAIN_P, 8'd255);
    add_write(REG_GAIN_I, 8'd255);
    add_write(REG_GAIN_D, 8'd255);
    add_write(REG_SETPOINT, 8'd255);
    add_write(REG_TANK_DEPTH, 8'd0);
    add_echo(16'd0);
    add_echo(16'hFFFF);
    add_write(REG_SETPOINT, 8'd0);
    add_write(REG_TANK_DEPTH, 8'd255);
    add_echo(16'd0);
    add_echo(16'd580);
    // moderate gains around the setpoint
    add_write(REG_GAIN_P, 8'd10);
    add_write(REG_GAIN_I, 8'd10);
    add_write(REG_GAIN_D, 8'd10);
    add_write(REG_SETPOINT, 8'd25);
    add_write(REG_TANK_DEPTH, 8'd30);
    add_echo(16'd290);
    add_echo(16'd1740);
    add_echo(16'd0);
    // open loop: only bit 0 of the mode write counts; manual duty saturates
    add_write(REG_CLOSED_LOOP, 8'hFE);
    add_write(REG_MANUAL_DUTY, 8'd255);
    add_echo(16'd1000);
    add_write(REG_MANUAL_DUTY, 8'd199);
    add_echo(16'd2000);
    add_write(REG_MANUAL_DUTY, 8'd0);
    add_echo(16'hFFFF);
    add_write(REG_SPARE, 8'hFF);
    add_write(REG_MANUAL_DUTY, 8'd200);
    add_echo(16'd3000);
    add_write(REG_CLOSED_LOOP, 8'h01);
    add_echo(16'd1200);

    // random phases, mostly echoes near the setpoint so the loop settles and swings
    for (ph = 0; ph < 10; ph++) begin
      sp = BYTE_W'($urandom_range(0, 255));
      dp = BYTE_W'($urandom_range(0, 255));
      if (ph == 3) begin
        sp = 8'd255;
        dp = 8'd0;
      end
      add_write(REG_SETPOINT, sp);
      add_write(REG_TANK_DEPTH, dp);
      if ($urandom_range(0, 1)) add_write(REG_GAIN_P, pick_gain());
      if ($urandom_range(0, 1)) add_write(REG_GAIN_I, pick_gain());
      if ($urandom_range(0, 1)) add_write(REG_GAIN_D, pick_gain());
      if ($urandom_range(0, 1)) add_write(REG_MANUAL_DUTY, BYTE_W'($urandom_range(0, 255)));
      add_write(REG_CLOSED_LOOP,
                {(BYTE_W-1)'($urandom_range(0, 127)), 1'b0}
                | BYTE_W'($urandom_range(0, 4) != 0));
      center = int'(dp) - int'(sp);
      for (n = 0; n < 48; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          e = ECHO_W'($urandom_range(0, 65535));
        end else begin
          dist_pick = center + int'($urandom_range(0, 40)) - 20;
          if (dist_pick < 0) dist_pick = 0;
          else if (dist_pick > 255) dist_pick = 255;
          e = ECHO_W'(dist_pick * ECHO_PER_CM + int'($urandom_range(0, ECHO_PER_CM - 1)));
        end
        add_echo(e);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (echo_plan.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("level_pid_step: match");
    end else begin
      $display("level_pid_step: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ERROR: run did not finish in time");
    $display("level_pid_step: mismatch");
    $finish;
  end

endmodule
